// File: hw/rtl/wcej_pkg.sv
// wcej_pkg: shared types and constants of the wide code to euc-jp decoder
// used by every module of the block; no dependencies

package wcej_pkg;

   localparam int WCEJ_MAX_BYTES   = 5;
   localparam int WCEJ_QUEUE_DEPTH = 2;

   localparam logic [7:0] HALF_HEAD = 8'h8E;
   localparam logic [7:0] SUPP_HEAD = 8'h8F;
   localparam logic [7:0] FW_A_LO   = 8'hA1;
   localparam logic [7:0] FW_A_HI   = 8'hA8;
   localparam logic [7:0] FW_B_LO   = 8'hB0;
   localparam logic [7:0] FW_B_HI   = 8'hF4;
   localparam logic [15:0] CIRC_LO  = 16'hADA1;
   localparam logic [15:0] CIRC_HI  = 16'hADB4;
   localparam logic [7:0] CIRC_BASE = 8'hA0;
   localparam logic [7:0] ASC_OPEN  = 8'h28;
   localparam logic [7:0] ASC_CLOSE = 8'h29;
   localparam logic [7:0] ASC_ZERO  = 8'h30;
   localparam logic [7:0] TERM_BYTE = 8'h00;

   // class code is {code[15], code[7]}
   typedef enum logic [1:0] {
      CLS_ASCII = 2'b00,
      CLS_HALF  = 2'b01,
      CLS_SUPP  = 2'b10,
      CLS_FULL  = 2'b11
   } wcej_class_type;

   typedef struct packed {
      logic [WCEJ_MAX_BYTES-1:0][7:0] bytes;
      logic [2:0]                     count;
   } wcej_entry_type;

   typedef struct packed {
      logic head_valid;
      logic not_full;
   } wcej_q_stat_type;

endpackage

// File: hw/rtl/wcej_req_if.sv
// wcej_req_if: request channel carrying one wide code per word
// depends on nothing

interface wcej_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code;
   logic        final_code;

   modport source (output valid, output code, output final_code, input ready);
   modport sink   (input valid, input code, input final_code, output ready);
endinterface

// File: hw/rtl/wcej_rsp_if.sv
// wcej_rsp_if: response channel carrying one output byte per word
// depends on nothing

interface wcej_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       end_of_run;

   modport source (output valid, output out_byte, output end_of_run, input ready);
   modport sink   (input valid, input out_byte, input end_of_run, output ready);
endinterface

// File: hw/rtl/wide_code_to_euc_jp_decoder_core.sv
// wide_code_to_euc_jp_decoder_core: top level, wide codes in, euc-jp bytes out
// depends on wcej_pkg, wcej_req_if, wcej_rsp_if, wcej_front, wcej_queue, wcej_back
//
//   channel  dir  word                      handshake
//   req_ch   in   code[15:0], final_code    valid/ready
//   rsp_ch   out  out_byte[7:0], end_of_run valid/ready
//
// each code gives one to five output bytes; the back end's byte sequencer
// sends them one per cycle while rsp_ch is ready, and codes with no bytes are
// dropped; the front end classifies a code in its accept cycle and queues
// its bytes; the first byte reaches rsp_ch through the queue and output register
// reset is synchronous, active high, and clears queue and output valid
// a stalled output holds its byte while the queue keeps taking codes until full

module wide_code_to_euc_jp_decoder_core
   import wcej_pkg::*;
#(
   parameter int QUEUE_DEPTH = WCEJ_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   wcej_req_if.sink   req_ch,
   wcej_rsp_if.source rsp_ch
);

   wcej_q_stat_type q_stat;
   wcej_entry_type  push_entry;
   wcej_entry_type  head_entry;
   logic            push_valid;
   logic            pop;

   wcej_front u_front (
      .req_ch     (req_ch),
      .q_stat     (q_stat),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   wcej_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .q_stat     (q_stat),
      .head_entry (head_entry)
   );

   wcej_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

// File: hw/rtl/wcej_front.sv
// wcej_front: accepts request words and classifies them into byte bundles
// depends on wcej_pkg and wcej_req_if

module wcej_front
   import wcej_pkg::*;
(
   wcej_req_if.sink        req_ch,
   input  wcej_q_stat_type q_stat,
   output logic            push_valid,
   output wcej_entry_type  push_entry
);

   wcej_class_type cls;
   logic [7:0]     hi;
   logic [7:0]     lo;
   logic [7:0]     num;
   logic [7:0]     tens;
   logic [7:0]     units;
   logic           in_range_a;
   logic           in_range_b;
   logic           is_circ;

   assign hi  = req_ch.code[15:8];
   assign lo  = req_ch.code[7:0];
   assign cls = wcej_class_type'({req_ch.code[15], req_ch.code[7]});

   assign in_range_a = (hi >= FW_A_LO) && (hi <= FW_A_HI);
   assign in_range_b = (hi >= FW_B_LO) && (hi <= FW_B_HI);
   assign is_circ    = (req_ch.code >= CIRC_LO) && (req_ch.code <= CIRC_HI);

   // circled number split into decimal digits
   always_comb begin
      num = lo - CIRC_BASE;
      if (num >= 8'd20) begin
         tens  = 8'd2;
         units = num - 8'd20;
      end else if (num >= 8'd10) begin
         tens  = 8'd1;
         units = num - 8'd10;
      end else begin
         tens  = 8'd0;
         units = num;
      end
   end

   always_comb begin
      push_entry = '0;
      case (cls)
         CLS_ASCII: begin
            push_entry.bytes[0] = {1'b0, req_ch.code[6:0]};
            push_entry.count    = 3'd1;
         end
         CLS_HALF: begin
            push_entry.bytes[0] = HALF_HEAD;
            push_entry.bytes[1] = {1'b1, req_ch.code[6:0]};
            push_entry.count    = 3'd2;
         end
         CLS_SUPP: begin
            push_entry.bytes[0] = SUPP_HEAD;
            push_entry.bytes[1] = hi;
            push_entry.bytes[2] = {1'b1, lo[6:0]};
            push_entry.count    = 3'd3;
         end
         CLS_FULL: begin
            if (in_range_a || in_range_b) begin
               push_entry.bytes[0] = hi;
               push_entry.bytes[1] = lo;
               push_entry.count    = 3'd2;
            end else if (is_circ) begin
               push_entry.bytes[0] = ASC_OPEN;
               if (tens != 8'd0) begin
                  push_entry.bytes[1] = ASC_ZERO + tens;
                  push_entry.bytes[2] = ASC_ZERO + units;
                  push_entry.bytes[3] = ASC_CLOSE;
                  push_entry.count    = 3'd4;
               end else begin
                  push_entry.bytes[1] = ASC_ZERO + units;
                  push_entry.bytes[2] = ASC_CLOSE;
                  push_entry.count    = 3'd3;
               end
            end
         end
         default: begin
            push_entry = '0;
         end
      endcase
      // terminator after the last code of a string
      if (req_ch.final_code) begin
         push_entry.bytes[push_entry.count] = TERM_BYTE;
         push_entry.count = push_entry.count + 3'd1;
      end
   end

   assign req_ch.ready = q_stat.not_full;
   // words that give no bytes are dropped here
   assign push_valid   = req_ch.valid && q_stat.not_full && (push_entry.count != 3'd0);

endmodule

// File: hw/rtl/wcej_queue.sv
// wcej_queue: short fifo of byte bundles between front and back
// depends on wcej_pkg

module wcej_queue
   import wcej_pkg::*;
#(
   parameter int QUEUE_DEPTH = WCEJ_QUEUE_DEPTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   input  wcej_entry_type  push_entry,
   input  logic            pop,
   output wcej_q_stat_type q_stat,
   output wcej_entry_type  head_entry
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

   wcej_entry_type mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           do_pop;

   assign do_pop = pop && (cnt_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push_valid && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry        = mem_ff[rd_ptr_ff];
   assign q_stat.head_valid = (cnt_ff != '0);
   assign q_stat.not_full   = (cnt_ff != FULL_CNT);

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_CNT)
      else $error("queue count above depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == FULL_CNT) |-> !push_valid)
      else $error("push into full queue");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      ((cnt_ff == '0) || (cnt_ff == FULL_CNT)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers out of step with count");

endmodule

// File: hw/rtl/wcej_back.sv
// wcej_back: sends the head bundle's bytes one per cycle while rsp_ch is ready
// depends on wcej_pkg and wcej_rsp_if

module wcej_back
   import wcej_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  wcej_q_stat_type q_stat,
   input  wcej_entry_type  head_entry,
   output logic            pop,
   wcej_rsp_if.source      rsp_ch
);

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       eor_ff, eor_in;
   logic       load;
   logic       last;

   assign load = q_stat.head_valid && (!valid_ff || rsp_ch.ready);
   assign last = (idx_ff == head_entry.count - 3'd1);
   assign pop  = load && last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_ch.ready;
      byte_in  = byte_ff;
      eor_in   = eor_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = head_entry.bytes[idx_ff];
         eor_in   = last;
         idx_in   = last ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      eor_ff  <= eor_in;
   end

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.out_byte   = byte_ff;
   assign rsp_ch.end_of_run = eor_ff;

   a_idx_in_bundle: assert property (@(posedge clock) disable iff (reset)
      q_stat.head_valid |-> (idx_ff < head_entry.count))
      else $error("byte index past bundle");

   a_pop_marks_end: assert property (@(posedge clock) disable iff (reset)
      pop |=> (valid_ff && eor_ff))
      else $error("bundle retired without end of run");

   a_idx_restart: assert property (@(posedge clock) disable iff (reset)
      pop |=> (idx_ff == 3'd0))
      else $error("index not cleared after bundle");

endmodule
